// ===== hw/rtl/gdd_pkg.sv =====
// ============================================================================
// gdd_pkg - shared types and constants for the date difference block
// Field widths, order codes and the pipeline enable bundle.
// ============================================================================
package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int DIST_W  = 22;
    localparam int ORDER_W = 2;
    // Day number of the largest 14-bit year still fits 23 bits.
    localparam int NUM_W   = 23;

    localparam logic signed [ORDER_W-1:0] ORD_LATER   = 2'sb01;
    localparam logic signed [ORDER_W-1:0] ORD_EQUAL   = 2'sb00;
    localparam logic signed [ORDER_W-1:0] ORD_EARLIER = 2'sb11;

    // Load enables of the three pipeline stages.
    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
    } t_pipe_en;

endpackage

// ===== hw/rtl/gdd_if.sv =====
// ============================================================================
// gdd_if - request and response channels
// Valid/ready channels carrying a date pair and its day distance.
// ============================================================================
interface gdd_req_if;
    import gdd_pkg::*;

    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;

    modport source (
        output valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        input  ready
    );
    modport sink (
        input  valid, first_day, first_month, first_year,
               second_day, second_month, second_year,
        output ready
    );
endinterface

interface gdd_rsp_if;
    import gdd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [DIST_W-1:0]         day_distance;
    logic signed [ORDER_W-1:0] order;

    modport source (
        output valid, day_distance, order,
        input  ready
    );
    modport sink (
        input  valid, day_distance, order,
        output ready
    );
endinterface

// ===== hw/rtl/gdd_lane.sv =====
// ============================================================================
// gdd_lane - day number of one date
// Two stages: constant multiplies, then the leap test and the final sum.
// ============================================================================
module gdd_lane (
    input  logic                         i_clk,
    input  gdd_pkg::t_pipe_en            i_en,
    input  logic [gdd_pkg::DAY_W-1:0]    i_day,
    input  logic [gdd_pkg::MONTH_W-1:0]  i_month,
    input  logic [gdd_pkg::YEAR_W-1:0]   i_year,
    output logic [gdd_pkg::NUM_W-1:0]    o_day_num
);
    import gdd_pkg::*;

    localparam int QW = 8;              // quotient of a 12-bit value by 25
    localparam int XW = YEAR_W - 2;

    localparam logic [8:0] DAYS_BEFORE [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
    };

    // floor(x / 25) for x < 4096: x * 1311 / 32768 is exact over that range.
    function automatic logic [QW-1:0] div25(input logic [XW-1:0] x);
        logic [23:0] prod;
        begin
            prod  = 24'(x) * 24'd1311;
            div25 = prod[22:15];
        end
    endfunction

    logic [YEAR_W-1:0]  w_prev;
    logic [NUM_W-1:0]   w_whole;
    logic               w_div100;
    logic               w_leap;
    logic [NUM_W-1:0]   w_sum;

    // stage A
    logic [NUM_W-1:0]   r_y365;
    logic [XW-1:0]      r_p4;
    logic [QW-1:0]      r_q100;
    logic [QW-1:0]      r_q400;
    logic [XW-1:0]      r_y4;
    logic [QW-1:0]      r_qy;
    logic [1:0]         r_ylo;
    logic               r_ynz;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]   r_day;
    // stage B
    logic [NUM_W-1:0]   r_num;

    assign w_prev = i_year - YEAR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_en.en_a) begin
            r_y365  <= NUM_W'(i_year) * NUM_W'(365);
            r_p4    <= w_prev[YEAR_W-1:2];
            r_q100  <= div25(w_prev[YEAR_W-1:2]);
            r_q400  <= div25({2'b00, w_prev[YEAR_W-1:4]});
            r_y4    <= i_year[YEAR_W-1:2];
            r_qy    <= div25(i_year[YEAR_W-1:2]);
            r_ylo   <= i_year[1:0];
            r_ynz   <= (i_year != '0);
            r_month <= i_month;
            r_day   <= i_day;
        end
    end

    // Leap: divisible by 4, and either not by 100 or year/100 divisible by 4.
    always_comb begin
        w_div100 = (r_y4 == XW'({4'b0000, r_qy} * 12'd25));
        w_leap   = (r_ylo == 2'b00) && (!w_div100 || (r_qy[1:0] == 2'b00));
        w_whole  = r_ynz ? (NUM_W'(r_p4) - NUM_W'(r_q100) + NUM_W'(r_q400) + NUM_W'(1))
                         : '0;
        w_sum    = r_y365 + w_whole + NUM_W'(DAYS_BEFORE[r_month])
                 + NUM_W'(w_leap && (r_month > MONTH_W'(2))) + NUM_W'(r_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_b) begin
            r_num <= w_sum;
        end
    end

    assign o_day_num = r_num;

endmodule

// ===== hw/rtl/gdd_merge.sv =====
// ============================================================================
// gdd_merge - combines the two lanes
// Field order compare, absolute difference and saturation.
// ============================================================================
module gdd_merge (
    input  logic                               i_clk,
    input  gdd_pkg::t_pipe_en                  i_en,
    input  logic [gdd_pkg::DAY_W-1:0]          i_first_day,
    input  logic [gdd_pkg::MONTH_W-1:0]        i_first_month,
    input  logic [gdd_pkg::YEAR_W-1:0]         i_first_year,
    input  logic [gdd_pkg::DAY_W-1:0]          i_second_day,
    input  logic [gdd_pkg::MONTH_W-1:0]       i_second_month,
    input  logic [gdd_pkg::YEAR_W-1:0]         i_second_year,
    input  logic [gdd_pkg::NUM_W-1:0]          i_num_first,
    input  logic [gdd_pkg::NUM_W-1:0]          i_num_second,
    output logic [gdd_pkg::DIST_W-1:0]         o_distance,
    output logic signed [gdd_pkg::ORDER_W-1:0] o_order
);
    import gdd_pkg::*;

    logic signed [ORDER_W-1:0] w_ord;
    logic [NUM_W-1:0]          w_diff;
    logic [DIST_W-1:0]         w_dist;

    logic signed [ORDER_W-1:0] r_ord_a;
    logic signed [ORDER_W-1:0] r_ord_b;
    logic signed [ORDER_W-1:0] r_ord_c;
    logic [DIST_W-1:0]         r_dist;

    always_comb begin
        priority if (i_first_year > i_second_year)   w_ord = ORD_LATER;
        else if (i_first_year < i_second_year)       w_ord = ORD_EARLIER;
        else if (i_first_month > i_second_month)     w_ord = ORD_LATER;
        else if (i_first_month < i_second_month)     w_ord = ORD_EARLIER;
        else if (i_first_day > i_second_day)         w_ord = ORD_LATER;
        else if (i_first_day < i_second_day)         w_ord = ORD_EARLIER;
        else                                         w_ord = ORD_EQUAL;
    end

    always_comb begin
        w_diff = (i_num_first >= i_num_second) ? (i_num_first - i_num_second)
                                               : (i_num_second - i_num_first);
        w_dist = w_diff[NUM_W-1] ? '1 : w_diff[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_a) begin
            r_ord_a <= w_ord;
        end
        if (i_en.en_b) begin
            r_ord_b <= r_ord_a;
        end
        if (i_en.en_c) begin
            r_ord_c <= r_ord_b;
            r_dist  <= w_dist;
        end
    end

    assign o_distance = r_dist;
    assign o_order    = r_ord_c;

endmodule

// ===== hw/rtl/gregorian_date_difference.sv =====
// ============================================================================
// gregorian_date_difference - days between two Gregorian dates
// Two day-number lanes feeding a merge stage, three-stage pipeline.
// ============================================================================
// Takes a request holding two dates (day, month, year from year 0) and
// answers with the absolute number of days between them and their order
// (1 first later, 0 equal, -1 first earlier, compared year, month, day).
// One request is taken per clock unless back pressure fills every stage;
// each passes through three register stages: constant multiplies in each
// lane, the day-number sum in each lane, and the difference in the merge
// stage. Each stage holds its item when the one after it cannot load, so
// a request is still accepted while a response waits if a stage is free.
// Days and months are not range checked; a month above twelve counts the
// whole year, and a distance beyond 22 bits saturates to all ones.
// ============================================================================
module gregorian_date_difference (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gdd_req_if.sink   i_req,
    gdd_rsp_if.source o_rsp
);
    import gdd_pkg::*;

    // stage valid flags and their next values
    logic r_v_a, r_v_b, r_v_c;
    logic n_v_a, n_v_b, n_v_c;

    // a stage may load when empty or when its content moves on
    logic w_rdy_a, w_rdy_b, w_rdy_c;
    t_pipe_en w_en;

    logic [NUM_W-1:0] w_num_first;
    logic [NUM_W-1:0] w_num_second;

    always_comb begin
        w_rdy_c   = !r_v_c || o_rsp.ready;
        w_rdy_b   = !r_v_b || w_rdy_c;
        w_rdy_a   = !r_v_a || w_rdy_b;
        w_en.en_a = w_rdy_a;
        w_en.en_b = w_rdy_b;
        w_en.en_c = w_rdy_c;
        n_v_a     = w_rdy_a ? i_req.valid : r_v_a;
        n_v_b     = w_rdy_b ? r_v_a       : r_v_b;
        n_v_c     = w_rdy_c ? r_v_b       : r_v_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_v_c <= 1'b0;
        end else begin
            r_v_a <= n_v_a;
            r_v_b <= n_v_b;
            r_v_c <= n_v_c;
        end
    end

    assign i_req.ready = w_rdy_a;
    assign o_rsp.valid = r_v_c;

    // lane for the first date
    gdd_lane u_lane_first (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_day     (i_req.first_day),
        .i_month   (i_req.first_month),
        .i_year    (i_req.first_year),
        .o_day_num (w_num_first)
    );

    // lane for the second date
    gdd_lane u_lane_second (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_day     (i_req.second_day),
        .i_month   (i_req.second_month),
        .i_year    (i_req.second_year),
        .o_day_num (w_num_second)
    );

    // order from the raw fields, distance from the lane results
    gdd_merge u_merge (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_first_day    (i_req.first_day),
        .i_first_month  (i_req.first_month),
        .i_first_year   (i_req.first_year),
        .i_second_day   (i_req.second_day),
        .i_second_month (i_req.second_month),
        .i_second_year  (i_req.second_year),
        .i_num_first    (w_num_first),
        .i_num_second   (w_num_second),
        .o_distance     (o_rsp.day_distance),
        .o_order        (o_rsp.order)
    );

    // identical fields give identical day numbers
    a_equal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.order == ORD_EQUAL) |-> (o_rsp.day_distance == '0))
        else $error("equal dates with nonzero distance");

    // back pressure only when every stage holds an item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_v_a && r_v_b && r_v_c))
        else $error("request refused with a free stage");

    // an accepted request occupies the first stage
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_v_a)
        else $error("accepted request lost");

    // order code is never the unused pattern
    a_order_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.order == ORD_LATER || o_rsp.order == ORD_EQUAL ||
                         o_rsp.order == ORD_EARLIER))
        else $error("bad order code");

endmodule

// ===== bench/date_gap_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// date_gap_checker - response checker for the date difference block
// Predicts day distance and order for each accepted request and compares
// every accepted response with the oldest outstanding prediction.
// ============================================================================
module date_gap_checker
    import gdd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gdd_req_if   i_req,
    gdd_rsp_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int unsigned GAP_CEILING = (1 << DIST_W) - 1;

    typedef struct packed {
        logic [DIST_W-1:0]         gap;
        logic signed [ORDER_W-1:0] ord;
    } gap_answer_t;

    gap_answer_t awaited_gaps[$];
    gap_answer_t oldest;
    int          fail_total = 0;

    // Days from the start of year 0 up to and including the given date.
    function automatic int unsigned day_count(input logic [DAY_W-1:0]   day,
                                              input logic [MONTH_W-1:0] month,
                                              input logic [YEAR_W-1:0]  year);
        int unsigned y;
        int unsigned total;
        int unsigned month_start;
        y     = year;
        total = 365 * y;
        // leap days of the whole years before; year 0 is itself leap
        if (y > 0)
            total += (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
        case (month)
            4'd0, 4'd1: month_start = 0;
            4'd2:       month_start = 31;
            4'd3:       month_start = 59;
            4'd4:       month_start = 90;
            4'd5:       month_start = 120;
            4'd6:       month_start = 151;
            4'd7:       month_start = 181;
            4'd8:       month_start = 212;
            4'd9:       month_start = 243;
            4'd10:      month_start = 273;
            4'd11:      month_start = 304;
            4'd12:      month_start = 334;
            default:    month_start = 365;  // past December: whole year
        endcase
        total += month_start;
        if (month > 2 && (y % 400 == 0 || (y % 100 != 0 && y % 4 == 0)))
            total += 1;
        return total + day;
    endfunction

    function automatic gap_answer_t predict_gap(
        input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1,
        input logic [YEAR_W-1:0] y1, input logic [DAY_W-1:0] d2,
        input logic [MONTH_W-1:0] m2, input logic [YEAR_W-1:0] y2);
        int unsigned n1;
        int unsigned n2;
        int unsigned span;
        gap_answer_t answer;
        n1   = day_count(d1, m1, y1);
        n2   = day_count(d2, m2, y2);
        span = (n1 >= n2) ? n1 - n2 : n2 - n1;
        answer.gap = (span > GAP_CEILING) ? DIST_W'(GAP_CEILING) : DIST_W'(span);
        // order looks at raw fields, year first
        if ({y1, m1, d1} > {y2, m2, d2})
            answer.ord = ORD_LATER;
        else if ({y1, m1, d1} < {y2, m2, d2})
            answer.ord = ORD_EARLIER;
        else
            answer.ord = ORD_EQUAL;
        return answer;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_gaps.delete();
        end else begin
            if (i_req.valid && i_req.ready)
                awaited_gaps.push_back(predict_gap(i_req.first_day, i_req.first_month,
                                                   i_req.first_year, i_req.second_day,
                                                   i_req.second_month, i_req.second_year));
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_gaps.size() == 0) begin
                    $display("%0t: response with no request outstanding: distance %0d order %0d",
                             $time, i_rsp.day_distance, $signed(i_rsp.order));
                    fail_total++;
                end else begin
                    oldest = awaited_gaps.pop_front();
                    if (i_rsp.day_distance !== oldest.gap) begin
                        $display("%0t: day_distance mismatch: expected %0d, actual %0d",
                                 $time, oldest.gap, i_rsp.day_distance);
                        fail_total++;
                    end
                    if (i_rsp.order !== oldest.ord) begin
                        $display("%0t: order mismatch: expected %0d, actual %0d",
                                 $time, $signed(oldest.ord), $signed(i_rsp.order));
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_gaps.size();
    end

endmodule

// ===== bench/tb_gregorian_date_difference.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_gregorian_date_difference - testbench for the date difference block
// Drives date pairs in random bursts, stalls the response side on its own
// pattern, and leaves prediction and comparison to date_gap_checker.
// ============================================================================
module tb_gregorian_date_difference;
    import gdd_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_PAIRS = 700;
    // pipeline is three deep; extra drain cycles catch stray responses
    localparam int DRAIN_CYCLES = 8;
    // hang guard for the whole run
    localparam int CYCLE_LIMIT  = 200000;

    // response-side stall behaviors, switched after a random span
    typedef enum int {
        DRAIN_FREE,     // always ready
        DRAIN_COIN,     // ready half the time
        DRAIN_SCARCE,   // ready one cycle in four
        DRAIN_PATTERN   // fixed 8-bit pattern chosen at start
    } t_drain_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int          cycle_count = 0;
    int          fail_count;
    int          pending_count;
    int          burst_left = 0;
    logic [7:0]  stall_pattern;
    t_drain_mode drain_mode = DRAIN_FREE;
    int          drain_span = 0;

    gdd_req_if req_bus();
    gdd_rsp_if rsp_bus();

    gregorian_date_difference dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    date_gap_checker u_gap_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Hard stop if the pipeline hangs.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // Response side: pick a stall behavior, hold it for a random span.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (drain_span == 0) begin
                drain_mode <= t_drain_mode'($urandom_range(0, 3));
                drain_span <= $urandom_range(16, 96);
            end else begin
                drain_span <= drain_span - 1;
            end
            case (drain_mode)
                DRAIN_FREE:    rsp_bus.ready <= 1'b1;
                DRAIN_COIN:    rsp_bus.ready <= 1'($urandom_range(0, 1));
                DRAIN_SCARCE:  rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                default:       rsp_bus.ready <= stall_pattern[cycle_count[2:0]];
            endcase
        end
    end

    // Days in a calendar month, only used to build well-formed dates.
    function automatic int days_in_month(input logic [MONTH_W-1:0] m,
                                         input logic [YEAR_W-1:0]  y);
        case (m)
            4'd2:                    return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0)
                                            ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            default:                 return 31;
        endcase
    endfunction

    task automatic random_date(output logic [DAY_W-1:0]   d,
                               output logic [MONTH_W-1:0] m,
                               output logic [YEAR_W-1:0]  y);
        y = YEAR_W'($urandom_range(0, 9999));
        m = MONTH_W'($urandom_range(1, 12));
        d = DAY_W'($urandom_range(1, days_in_month(m, y)));
    endtask

    // Present one request and hold it until taken. Valid stays high within
    // a burst; at the end of a burst it drops for a random gap.
    task automatic send_pair(input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1,
                             input logic [YEAR_W-1:0] y1, input logic [DAY_W-1:0] d2,
                             input logic [MONTH_W-1:0] m2, input logic [YEAR_W-1:0] y2);
        req_bus.valid        <= 1'b1;
        req_bus.first_day    <= d1;
        req_bus.first_month  <= m1;
        req_bus.first_year   <= y1;
        req_bus.second_day   <= d2;
        req_bus.second_month <= m2;
        req_bus.second_year  <= y2;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        if (burst_left == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // mostly short bursts, now and then a long unbroken stream
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    initial begin
        logic [DAY_W-1:0]   d1;
        logic [DAY_W-1:0]   d2;
        logic [MONTH_W-1:0] m1;
        logic [MONTH_W-1:0] m2;
        logic [YEAR_W-1:0]  y1;
        logic [YEAR_W-1:0]  y2;
        int                 pick;

        i_rst_n              = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.first_day    = '0;
        req_bus.first_month  = '0;
        req_bus.first_year   = '0;
        req_bus.second_day   = '0;
        req_bus.second_month = '0;
        req_bus.second_year  = '0;
        stall_pattern        = 8'($urandom);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed requests ----
        send_pair(5'd1,  4'd1,  14'd0,     5'd1,  4'd1,  14'd0);     // identical dates
        send_pair(5'd1,  4'd1,  14'd1,     5'd1,  4'd1,  14'd0);     // year 0 is leap
        send_pair(5'd29, 4'd2,  14'd2000,  5'd1,  4'd3,  14'd2000);  // 400-year leap
        send_pair(5'd28, 4'd2,  14'd1900,  5'd1,  4'd3,  14'd1900);  // century, not leap
        send_pair(5'd29, 4'd2,  14'd2024,  5'd1,  4'd3,  14'd2023);
        send_pair(5'd31, 4'd12, 14'd9999,  5'd1,  4'd1,  14'd0);     // widest legal span
        send_pair(5'd1,  4'd1,  14'd0,     5'd31, 4'd12, 14'd9999);
        // unchecked days: day zero and a day past month end
        send_pair(5'd0,  4'd3,  14'd2001,  5'd28, 4'd2,  14'd2001);
        send_pair(5'd31, 4'd2,  14'd2001,  5'd3,  4'd3,  14'd2001);
        // month zero counts no earlier months
        send_pair(5'd5,  4'd0,  14'd2020,  5'd5,  4'd1,  14'd2020);
        // months above twelve count the whole year
        send_pair(5'd1,  4'd13, 14'd2019,  5'd1,  4'd1,  14'd2020);
        send_pair(5'd17, 4'd15, 14'd2024,  5'd17, 4'd14, 14'd2024);
        // all-ones fields push the distance into saturation; the last pair stays below it
        send_pair(5'd31, 4'd15, 14'd16383, 5'd0,  4'd0,  14'd0);
        send_pair(5'd0,  4'd0,  14'd0,     5'd31, 4'd15, 14'd16383);
        send_pair(5'd31, 4'd15, 14'd16383, 5'd1,  4'd1,  14'd4000);
        send_pair(5'd1,  4'd1,  14'd16383, 5'd1,  4'd1,  14'd8192);
        // order settled by day, by month and by year
        send_pair(5'd15, 4'd6,  14'd2023,  5'd14, 4'd6,  14'd2023);
        send_pair(5'd1,  4'd7,  14'd2023,  5'd30, 4'd6,  14'd2023);
        send_pair(5'd31, 4'd12, 14'd1999,  5'd1,  4'd1,  14'd2000);
        send_pair(5'd1,  4'd1,  14'd400,   5'd1,  4'd1,  14'd0);
        send_pair(5'd1,  4'd1,  14'd100,   5'd1,  4'd1,  14'd0);
        send_pair(5'd1,  4'd3,  14'd0,     5'd29, 4'd2,  14'd0);

        // ---- random requests ----
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            pick = $urandom_range(0, 99);
            random_date(d1, m1, y1);
            random_date(d2, m2, y2);
            if (pick < 50) begin
                // two unrelated calendar dates: keep as drawn
            end else if (pick < 75) begin
                // nearby dates: same date, same month, same year or adjacent years
                y2 = y1;
                case ($urandom_range(0, 3))
                    0: begin
                        m2 = m1;
                        d2 = d1;
                    end
                    1:       m2 = m1;
                    2:       ;
                    default: y2 = (y1 < 9999) ? y1 + YEAR_W'(1) : y1 - YEAR_W'(1);
                endcase
            end else if (pick < 82) begin
                // around the end of February in quad and century years
                y1 = ($urandom_range(0, 1) == 0) ? YEAR_W'(4 * $urandom_range(0, 2499))
                                                 : YEAR_W'(100 * $urandom_range(0, 99));
                m1 = 4'd2;
                d1 = DAY_W'($urandom_range(28, 29));
                y2 = y1 + YEAR_W'($urandom_range(0, 1));
                m2 = 4'd3;
                d2 = 5'd1;
            end else begin
                // raw bits: out-of-range days, months and years too
                d1 = DAY_W'($urandom);
                m1 = MONTH_W'($urandom);
                y1 = YEAR_W'($urandom);
                d2 = DAY_W'($urandom);
                m2 = MONTH_W'($urandom);
                y2 = YEAR_W'($urandom);
            end
            send_pair(d1, m1, y1, d2, m2, y2);
        end

        req_bus.valid <= 1'b0;
        // let the checker's pending count include the last request
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
